// File: rtl/mxs_pkg.sv
// ----------------------------------------------------------------------------
// mxs_pkg
// Shared widths, trie node layout, datapath operation codes and the
// controller status bundle for the maximum-XOR run search.
// ----------------------------------------------------------------------------
package mxs_pkg;

    localparam int VALUE_BITS = 21;
    localparam int POS_BITS   = 11;
    localparam int NODE_BITS  = 15;
    localparam int LVL_BITS   = 5;
    localparam int MAX_ITEMS  = 1024;
    localparam int TRIE_NODES = 32768;

    localparam logic [POS_BITS-1:0]  MAX_POS   = POS_BITS'(MAX_ITEMS);
    localparam logic [LVL_BITS-1:0]  LVL_TOP   = LVL_BITS'(VALUE_BITS - 1);
    // init sweep writes root plus the all-zero path: addresses 0..VALUE_BITS
    localparam logic [LVL_BITS-1:0]  INIT_LAST = LVL_BITS'(VALUE_BITS);
    localparam logic [NODE_BITS-1:0] INIT_USED = NODE_BITS'(VALUE_BITS + 1);

    // internal node: two child pointers (0 = none); leaf: position in kid0
    typedef struct packed {
        logic [NODE_BITS-1:0] kid1;
        logic [NODE_BITS-1:0] kid0;
    } node_t;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_INIT   = 4'd1;
    localparam op_t OP_ACCEPT = 4'd2;
    localparam op_t OP_QWALK  = 4'd3;
    localparam op_t OP_QLEAF  = 4'd4;
    localparam op_t OP_IWALK  = 4'd5;
    localparam op_t OP_ICHAIN = 4'd6;
    localparam op_t OP_ILEAF  = 4'd7;
    localparam op_t OP_EMIT   = 4'd8;

    typedef struct packed {
        logic lvl_zero;
        logic init_done;
        logic miss;
        logic room;
        logic last;
    } stat_t;

endpackage

// File: rtl/mxs_in_if.sv
// ----------------------------------------------------------------------------
// mxs_in_if
// Input item channel: one sequence element and its last flag.
// ----------------------------------------------------------------------------
interface mxs_in_if;
    logic                           valid;
    logic                           ready;
    logic [mxs_pkg::VALUE_BITS-1:0] value;
    logic                           last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/mxs_out_if.sv
// ----------------------------------------------------------------------------
// mxs_out_if
// Result item channel: best XOR and the run's one-based start and end.
// ----------------------------------------------------------------------------
interface mxs_out_if;
    logic                           valid;
    logic                           ready;
    logic [mxs_pkg::VALUE_BITS-1:0] max_xor;
    logic [mxs_pkg::POS_BITS-1:0]   run_start;
    logic [mxs_pkg::POS_BITS-1:0]   run_end;

    modport source (output valid, output max_xor, output run_start, output run_end,
                    input ready);
    modport sink   (input valid, input max_xor, input run_start, input run_end,
                    output ready);
endinterface

// File: rtl/mxs_ctrl.sv
// ----------------------------------------------------------------------------
// mxs_ctrl
// Sequencer: init sweep, trie query walk, trie insert walk and result hand-off.
// Drives one datapath operation per cycle except while waiting for an item or an output slot.
// ----------------------------------------------------------------------------
module mxs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mxs_pkg::stat_t stat,
    output mxs_pkg::op_t   op
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_QWALK  = 3'd2;
    localparam logic [2:0] S_QLEAF  = 3'd3;
    localparam logic [2:0] S_IWALK  = 3'd4;
    localparam logic [2:0] S_ICHAIN = 3'd5;
    localparam logic [2:0] S_ILEAF  = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       emit_go;
    logic [2:0] after_insert;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign emit_go      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign after_insert = stat.last ? S_EMIT : S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        op         = mxs_pkg::OP_NONE;
        case (state_reg)
            S_INIT:
            begin
                op = mxs_pkg::OP_INIT;
                if (stat.init_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = mxs_pkg::OP_ACCEPT;
                    if (stat.room)
                    begin
                        state_next = S_QWALK;
                    end
                    else if (in_last)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_QWALK:
            begin
                op = mxs_pkg::OP_QWALK;
                if (stat.lvl_zero)
                begin
                    state_next = S_QLEAF;
                end
            end
            S_QLEAF:
            begin
                op         = mxs_pkg::OP_QLEAF;
                state_next = S_IWALK;
            end
            S_IWALK:
            begin
                op = mxs_pkg::OP_IWALK;
                if (stat.lvl_zero)
                begin
                    // existing path: leaf written in this cycle
                    state_next = stat.miss ? S_ILEAF : after_insert;
                end
                else if (stat.miss)
                begin
                    state_next = S_ICHAIN;
                end
            end
            S_ICHAIN:
            begin
                op = mxs_pkg::OP_ICHAIN;
                if (stat.lvl_zero)
                begin
                    state_next = S_ILEAF;
                end
            end
            S_ILEAF:
            begin
                op         = mxs_pkg::OP_ILEAF;
                state_next = after_insert;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    op         = mxs_pkg::OP_EMIT;
                    state_next = S_INIT;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/mxs_datapath.sv
// ----------------------------------------------------------------------------
// mxs_datapath
// Prefix, position and best-run registers plus the trie memory. Each trie
// level costs one memory access; the next read address comes straight from
// the registered read data so a walk advances one level per cycle.
// ----------------------------------------------------------------------------
module mxs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mxs_pkg::op_t                   op,
    input  logic [mxs_pkg::VALUE_BITS-1:0] in_value,
    input  logic                           in_last,
    output mxs_pkg::stat_t                 stat,
    output logic [mxs_pkg::VALUE_BITS-1:0] out_max_xor,
    output logic [mxs_pkg::POS_BITS-1:0]   out_run_start,
    output logic [mxs_pkg::POS_BITS-1:0]   out_run_end
);

    localparam int VB = mxs_pkg::VALUE_BITS;
    localparam int PB = mxs_pkg::POS_BITS;
    localparam int NB = mxs_pkg::NODE_BITS;
    localparam int LB = mxs_pkg::LVL_BITS;

    mxs_pkg::node_t trie_mem [mxs_pkg::TRIE_NODES];
    mxs_pkg::node_t rd_data_reg;

    logic [VB-1:0] prefix_reg, prefix_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [VB-1:0] best_reg, best_next;
    logic [PB-1:0] first_reg, first_next;
    logic [PB-1:0] end_reg, end_next;
    logic          last_reg, last_next;
    logic [NB-1:0] used_reg, used_next;
    logic [LB-1:0] init_reg, init_next;
    logic [LB-1:0] lvl_reg, lvl_next;
    logic [VB-1:0] key_reg, key_next;
    logic [VB-1:0] x_reg, x_next;
    logic [NB-1:0] cur_reg, cur_next;

    logic [VB-1:0] res_xor_reg;
    logic [PB-1:0] res_start_reg;
    logic [PB-1:0] res_end_reg;

    logic           we;
    logic [NB-1:0]  wr_addr;
    mxs_pkg::node_t wr_data;
    logic [NB-1:0]  rd_addr;

    logic          key_bit;
    logic [NB-1:0] kid_same;
    logic [NB-1:0] kid_want;
    logic [NB-1:0] kid_other;
    logic          room;
    logic [VB-1:0] key_shift;
    logic [PB-1:0] leaf_pos;
    mxs_pkg::node_t link_node;

    assign key_bit   = key_reg[VB-1];
    assign key_shift = {key_reg[VB-2:0], 1'b0};
    assign kid_same  = key_bit ? rd_data_reg.kid1 : rd_data_reg.kid0;
    assign kid_want  = key_bit ? rd_data_reg.kid0 : rd_data_reg.kid1;
    assign kid_other = kid_same;
    assign room      = (pos_reg < mxs_pkg::MAX_POS);
    assign leaf_pos  = rd_data_reg.kid0[PB-1:0];

    assign stat.lvl_zero  = (lvl_reg == '0);
    assign stat.init_done = (init_reg == mxs_pkg::INIT_LAST);
    assign stat.miss      = (kid_same == '0);
    assign stat.room      = room;
    assign stat.last      = last_reg;

    assign out_max_xor   = res_xor_reg;
    assign out_run_start = res_start_reg;
    assign out_run_end   = res_end_reg;

    always_comb
    begin
        prefix_next = prefix_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        first_next  = first_reg;
        end_next    = end_reg;
        last_next   = last_reg;
        used_next   = used_reg;
        init_next   = init_reg;
        lvl_next    = lvl_reg;
        key_next    = key_reg;
        x_next      = x_reg;
        cur_next    = cur_reg;
        we          = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = '0;
        rd_addr     = '0;
        link_node   = '0;

        case (op)
            mxs_pkg::OP_INIT:
            begin
                we        = 1'b1;
                wr_addr   = NB'(init_reg);
                if (init_reg != mxs_pkg::INIT_LAST)
                begin
                    wr_data.kid0 = NB'(init_reg) + NB'(1);
                end
                init_next = init_reg + LB'(1);
                used_next = mxs_pkg::INIT_USED;
            end
            mxs_pkg::OP_ACCEPT:
            begin
                last_next = in_last;
                if (room)
                begin
                    prefix_next = prefix_reg ^ in_value;
                    key_next    = prefix_reg ^ in_value;
                    pos_next    = pos_reg + PB'(1);
                    lvl_next    = mxs_pkg::LVL_TOP;
                end
            end
            mxs_pkg::OP_QWALK:
            begin
                // prefer the child that sets this XOR bit
                if (kid_want != '0)
                begin
                    rd_addr = kid_want;
                    x_next  = {x_reg[VB-2:0], 1'b1};
                end
                else
                begin
                    rd_addr = kid_other;
                    x_next  = {x_reg[VB-2:0], 1'b0};
                end
                key_next = key_shift;
                lvl_next = lvl_reg - LB'(1);
            end
            mxs_pkg::OP_QLEAF:
            begin
                if (end_reg == '0 || x_reg > best_reg)
                begin
                    best_next  = x_reg;
                    first_next = leaf_pos + PB'(1);
                    end_next   = pos_reg;
                end
                key_next = prefix_reg;
                lvl_next = mxs_pkg::LVL_TOP;
                cur_next = '0;
            end
            mxs_pkg::OP_IWALK:
            begin
                if (kid_same != '0)
                begin
                    rd_addr  = kid_same;
                    cur_next = kid_same;
                    if (lvl_reg == '0)
                    begin
                        // path exists: refresh leaf with newest position
                        we           = 1'b1;
                        wr_addr      = kid_same;
                        wr_data.kid0 = NB'(pos_reg);
                    end
                end
                else
                begin
                    link_node = rd_data_reg;
                    if (key_bit)
                    begin
                        link_node.kid1 = used_reg;
                    end
                    else
                    begin
                        link_node.kid0 = used_reg;
                    end
                    we        = 1'b1;
                    wr_addr   = cur_reg;
                    wr_data   = link_node;
                    cur_next  = used_reg;
                    used_next = used_reg + NB'(1);
                end
                key_next = key_shift;
                lvl_next = lvl_reg - LB'(1);
            end
            mxs_pkg::OP_ICHAIN:
            begin
                // fresh node: written once with its final child link
                we      = 1'b1;
                wr_addr = cur_reg;
                if (key_bit)
                begin
                    wr_data.kid1 = used_reg;
                end
                else
                begin
                    wr_data.kid0 = used_reg;
                end
                cur_next  = used_reg;
                used_next = used_reg + NB'(1);
                key_next  = key_shift;
                lvl_next  = lvl_reg - LB'(1);
            end
            mxs_pkg::OP_ILEAF:
            begin
                we           = 1'b1;
                wr_addr      = cur_reg;
                wr_data.kid0 = NB'(pos_reg);
            end
            mxs_pkg::OP_EMIT:
            begin
                prefix_next = '0;
                pos_next    = '0;
                best_next   = '0;
                first_next  = '0;
                end_next    = '0;
                init_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            trie_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= trie_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            pos_reg    <= '0;
            best_reg   <= '0;
            first_reg  <= '0;
            end_reg    <= '0;
            last_reg   <= 1'b0;
            used_reg   <= '0;
            init_reg   <= '0;
            lvl_reg    <= '0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            pos_reg    <= pos_next;
            best_reg   <= best_next;
            first_reg  <= first_next;
            end_reg    <= end_next;
            last_reg   <= last_next;
            used_reg   <= used_next;
            init_reg   <= init_next;
            lvl_reg    <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        x_reg   <= x_next;
        cur_reg <= cur_next;
        if (op == mxs_pkg::OP_EMIT)
        begin
            res_xor_reg   <= best_reg;
            res_start_reg <= first_reg;
            res_end_reg   <= end_reg;
        end
    end

endmodule

// File: rtl/max_xor_subarray_search.sv
// ----------------------------------------------------------------------------
// max_xor_subarray_search
// Greatest-XOR contiguous run over a sequence, using a prefix-XOR binary trie.
//
//   channel   dir   handshake       payload
//   items     in    valid / ready   value[20:0], last
//   results   out   valid / ready   max_xor[20:0], run_start[10:0], run_end[10:0]
//
// Each item runs accept, 21 query levels plus a leaf read, then a 21-level
// insert walk (plus a separate leaf write when the path is new), with one trie memory access per level.
// Items past 1024 in a sequence skip the trie walks and only act on last.
// After reset and after each result a sweep rebuilds the root and
// the zero path; items are not accepted meanwhile.
// A result waits in the output register; a later last item stalls only if
// that register is still full.
// ----------------------------------------------------------------------------
module max_xor_subarray_search (
    input  logic       clk,
    input  logic       rst_n,
    mxs_in_if.sink     items,
    mxs_out_if.source  results
);

    mxs_pkg::stat_t stat;
    mxs_pkg::op_t   op;

    mxs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_last   (items.last),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .op        (op)
    );

    mxs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .in_value      (items.value),
        .in_last       (items.last),
        .stat          (stat),
        .out_max_xor   (results.max_xor),
        .out_run_start (results.run_start),
        .out_run_end   (results.run_end)
    );

endmodule

// File: rtl/mxs_checker.sv
// ----------------------------------------------------------------------------
// mxs_checker
// Port-level checks for the run search, bound to the top level.
// ----------------------------------------------------------------------------
module mxs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mxs_pkg::VALUE_BITS-1:0] max_xor,
    input logic [mxs_pkg::POS_BITS-1:0]   run_start,
    input logic [mxs_pkg::POS_BITS-1:0]   run_end
);

    // result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(max_xor) && $stable(run_start)
                                    && $stable(run_end))
        else $error("stalled result changed");

    // a run never ends before it starts, and always covers an element
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_end != '0 && run_start != '0 && run_start <= run_end)
        else $error("bad run bounds");

    // a fresh result starts the trie rebuild: no item taken then
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !(in_valid && in_ready))
        else $error("item taken during rebuild");

endmodule

bind max_xor_subarray_search mxs_checker u_mxs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .max_xor   (results.max_xor),
    .run_start (results.run_start),
    .run_end   (results.run_end)
);

// File: tb/sv/max_xor_subarray_search_tb.sv
// ----------------------------------------------------------------------------
// max_xor_subarray_search_tb
// Drives sequences through the search block and checks every result against
// a brute-force predictor that scans all earlier prefixes, or a typed answer.
// Runs a short table of edge cases, then random sequences, one overrunning
// the element cap, under changing idle patterns and one long result stall.
// ----------------------------------------------------------------------------
module max_xor_subarray_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mxs_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1880;
    localparam int unsigned PHASE1_AT    = 1300;
    localparam int unsigned PHASE2_AT    = 1600;
    localparam int unsigned LONG_SEQ     = MAX_ITEMS + 6;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned SEND_IDLE [3] = '{6, 86, 0};
    localparam int unsigned RECV_IDLE [3] = '{86, 6, 0};

    typedef struct packed {
        logic [VALUE_BITS-1:0] max_xor;
        logic [POS_BITS-1:0]   run_start;
        logic [POS_BITS-1:0]   run_end;
    } run_t;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        bit                    typed;
        run_t                  want;
    } step_row_t;

    typedef enum {MIX_FULL, MIX_SMALL, MIX_ONEHOT, MIX_HIGH} value_mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mxs_in_if  items_if ();
    mxs_out_if results_if ();

    max_xor_subarray_search u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // search state of the predictor
    logic [VALUE_BITS-1:0] seq_prefix;
    int unsigned           seq_count;
    int unsigned           prefix_last_pos [bit [VALUE_BITS-1:0]];
    logic [VALUE_BITS-1:0] lead_xor;
    int unsigned           lead_first;
    int unsigned           lead_last;

    run_t        pending_runs [$];
    int unsigned fail_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_request = 1'b0;
    bit          hold_served = 1'b0;
    int unsigned stall_cycles = 0;

    // directed rows: typed rows are single-element sequences, answer is obvious; the rest use the predictor
    step_row_t directed_rows [22] = '{
        '{21'h000000, 1'b1, 1'b1, '{21'h000000, 11'd1, 11'd1}},
        '{21'h1FFFFF, 1'b1, 1'b1, '{21'h1FFFFF, 11'd1, 11'd1}},
        '{21'h1FFFFF, 1'b0, 1'b0, '0},
        '{21'h1FFFFF, 1'b0, 1'b0, '0},
        '{21'h000000, 1'b1, 1'b0, '0},
        '{21'h000005, 1'b0, 1'b0, '0},
        '{21'h000005, 1'b0, 1'b0, '0},
        '{21'h000005, 1'b1, 1'b0, '0},
        '{21'h155555, 1'b0, 1'b0, '0},
        '{21'h0AAAAA, 1'b0, 1'b0, '0},
        '{21'h100000, 1'b1, 1'b0, '0},
        '{21'h000001, 1'b0, 1'b0, '0},
        '{21'h000002, 1'b0, 1'b0, '0},
        '{21'h000004, 1'b0, 1'b0, '0},
        '{21'h080000, 1'b0, 1'b0, '0},
        '{21'h100000, 1'b1, 1'b0, '0},
        '{21'h000000, 1'b0, 1'b0, '0},
        '{21'h000000, 1'b0, 1'b0, '0},
        '{21'h000000, 1'b1, 1'b0, '0},
        '{21'h000003, 1'b0, 1'b0, '0},
        '{21'h000003, 1'b0, 1'b0, '0},
        '{21'h000001, 1'b1, 1'b0, '0}
    };

    function automatic void clear_search();
        seq_prefix = '0;
        seq_count  = 0;
        lead_xor   = '0;
        lead_first = 0;
        lead_last  = 0;
        prefix_last_pos.delete();
        prefix_last_pos[0] = 0;
    endfunction

    // partner = stored prefix giving the largest XOR; its latest position
    // sets the run start. After the first item, only a strictly larger XOR replaces the lead.
    function automatic bit advance_search(input logic [VALUE_BITS-1:0] v, input logic l,
                                          output run_t r);
        bit [VALUE_BITS-1:0] partner;
        bit [VALUE_BITS-1:0] top;
        bit [VALUE_BITS-1:0] cand;
        r = '0;
        if (seq_count < MAX_ITEMS)
        begin
            seq_prefix = seq_prefix ^ v;
            seq_count++;
            partner = '0;
            top = seq_prefix;
            foreach (prefix_last_pos[key])
            begin
                cand = seq_prefix ^ key;
                if (cand > top)
                begin
                    top = cand;
                    partner = key;
                end
            end
            if (lead_last == 0 || top > lead_xor)
            begin
                lead_xor   = top;
                lead_first = prefix_last_pos[partner] + 1;
                lead_last  = seq_count;
            end
            prefix_last_pos[seq_prefix] = seq_count;
        end
        if (!l)
            return 1'b0;
        r.max_xor   = lead_xor;
        r.run_start = POS_BITS'(lead_first);
        r.run_end   = POS_BITS'(lead_last);
        clear_search();
        return 1'b1;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(input value_mix_t mix);
        case (mix)
            MIX_FULL:   return VALUE_BITS'($urandom);
            MIX_SMALL:  return VALUE_BITS'($urandom_range(0, 7));
            MIX_ONEHOT: return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
            default:    return ~VALUE_BITS'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic feed_item(input logic [VALUE_BITS-1:0] v, input logic l,
                             input bit typed, input run_t want);
        run_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.value <= v;
        items_if.last  <= l;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        if (advance_search(v, l, predicted))
            pending_runs.push_back(typed ? want : predicted);
    endtask

    initial
    begin : stimulus
        int unsigned counted;
        int unsigned seq_len;
        int unsigned idx;
        int unsigned phase;
        int unsigned pick;
        bit          long_done;
        value_mix_t  mix;
        items_if.valid = 1'b0;
        items_if.value = '0;
        items_if.last  = 1'b0;
        clear_search();
        phase = 0;
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            feed_item(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        counted = 0;
        long_done = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (phase == 0 && counted >= PHASE1_AT)
            begin
                phase = 1;
                send_idle_pct = SEND_IDLE[1];
                recv_idle_pct = RECV_IDLE[1];
            end
            else if (phase == 1 && counted >= PHASE2_AT)
            begin
                phase = 2;
                send_idle_pct = SEND_IDLE[2];
                recv_idle_pct = RECV_IDLE[2];
                hold_request = 1'b1;
            end
            // one sequence runs past the element cap; the extras only matter through last
            if (!long_done)
            begin
                seq_len = LONG_SEQ;
                long_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    seq_len = $urandom_range(1, 6);
                else if (pick < 95)
                    seq_len = $urandom_range(7, 40);
                else
                    seq_len = $urandom_range(41, 150);
            end
            mix = value_mix_t'($urandom_range(0, 3));
            for (idx = 1; idx <= seq_len; idx++)
            begin
                feed_item(pick_value(mix), idx == seq_len, 1'b0, '0);
                if (idx <= MAX_ITEMS)
                    counted++;
            end
        end
        items_if.valid <= 1'b0;

        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_sink
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                // long back-pressure: the output register fills and input stalls
                hold_served = 1'b1;
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        run_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_runs.size() == 0)
            begin
                $error("unexpected result item: max_xor %h run_start %0d run_end %0d",
                       results_if.max_xor, results_if.run_start, results_if.run_end);
                fail_count++;
            end
            else
            begin
                want = pending_runs.pop_front();
                if (results_if.max_xor !== want.max_xor)
                begin
                    $error("max_xor: expected %h, got %h", want.max_xor, results_if.max_xor);
                    fail_count++;
                end
                if (results_if.run_start !== want.run_start)
                begin
                    $error("run_start: expected %0d, got %0d",
                           want.run_start, results_if.run_start);
                    fail_count++;
                end
                if (results_if.run_end !== want.run_end)
                begin
                    $error("run_end: expected %0d, got %0d", want.run_end, results_if.run_end);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
